FILE: design/urxf_pkg.sv
// Shared types and constants for the UART receive FIFO with clear-to-send flow control.
// No dependencies.
package urxf_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;

	localparam int unsigned THR_W = 7;
	localparam logic [THR_W-1:0] THR_RESET = 7'd58;

	localparam int unsigned KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_RECEIVE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd2;

	localparam int unsigned IN_W  = 8;
	localparam int unsigned OUT_W = 16;

	typedef struct packed {
		logic accept;
		logic load_rd;
	} urxf_cmd_t;

	typedef struct packed {
		logic pop;
	} urxf_stat_t;

endpackage

FILE: design/urxf_ctrl.sv
// Controller for the UART receive FIFO: handshake sequencing and output valid.
// Depends on urxf_pkg.
module urxf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  urxf_pkg::urxf_stat_t   stat,
	output urxf_pkg::urxf_cmd_t    cmd
);
	import urxf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_MEM  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	assign s_tready    = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid    = out_valid_q;
	assign cmd.accept  = s_tvalid && s_tready;
	assign cmd.load_rd = (state_q == S_MEM);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && stat.pop) begin
					state_n = S_MEM;
				end
			end
			S_MEM: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if ((cmd.accept && !stat.pop) || cmd.load_rd) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_mem_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MEM |=> state_q == S_IDLE)
		else $error("memory wait state lasted more than one cycle");

	a_mem_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MEM |=> m_tvalid)
		else $error("pop did not produce an output word");

	a_direct_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !stat.pop |=> m_tvalid && state_q == S_IDLE)
		else $error("non-pop word not presented next cycle");

endmodule

FILE: design/urxf_dpath.sv
// Datapath for the UART receive FIFO: byte store, pointers, fill count, push-back slot,
// clear-to-send and output register. Depends on urxf_pkg.
module urxf_dpath #(
	parameter int unsigned FIFO_DEPTH = urxf_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [urxf_pkg::IN_W-1:0]     s_tdata,
	input  logic [urxf_pkg::KIND_W-1:0]   s_tuser,
	output logic [urxf_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [urxf_pkg::THR_W-1:0]    cfg_data,
	input  urxf_pkg::urxf_cmd_t           cmd,
	output urxf_pkg::urxf_stat_t          stat
);
	import urxf_pkg::*;

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned XW = (CW > THR_W) ? CW + 1 : THR_W + 1;
	localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [7:0]       rd_q;
	logic [PW-1:0]    rp_q;
	logic [PW-1:0]    wp_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    fill_n;
	logic [CW-1:0]    fill_inc;
	logic [CW-1:0]    fill_dec;
	logic             cts_q;
	logic             cts_n;
	logic [7:0]       pushed_byte_q;
	logic             pushed_full_q;
	logic             pushed_full_n;
	logic [THR_W-1:0] thr_q;

	logic [7:0] out_byte_q;
	logic       out_rv_q;
	logic       out_drop_q;
	logic       out_cts_q;
	logic       out_av_q;

	logic [KIND_W-1:0] kind;
	logic [7:0]        din;
	logic is_rx, is_rd, is_push;
	logic fifo_full, fifo_empty;
	logic do_store, do_slot, do_pop;

	assign kind = s_tuser;
	assign din  = s_tdata[7:0];

	always_comb begin
		is_rx      = (kind == KIND_RECEIVE);
		is_rd      = (kind == KIND_READ);
		is_push    = (kind == KIND_PUSH);
		fifo_full  = (fill_q == FULL_CNT);
		fifo_empty = (fill_q == '0);
		do_store   = is_rx && !fifo_full;
		do_slot    = is_rd && pushed_full_q;
		do_pop     = is_rd && !pushed_full_q && !fifo_empty;
		fill_inc   = fill_q + CW'(1);
		fill_dec   = fill_q - CW'(1);

		fill_n = fill_q;
		cts_n  = cts_q;
		if (do_store) begin
			fill_n = fill_inc;
			if (XW'(fill_inc) >= XW'(thr_q)) begin
				cts_n = 1'b0;
			end
		end else if (do_pop) begin
			fill_n = fill_dec;
			if (XW'(fill_dec) < XW'(thr_q)) begin
				cts_n = 1'b1;
			end
		end

		pushed_full_n = pushed_full_q;
		if (is_push) begin
			pushed_full_n = 1'b1;
		end else if (do_slot) begin
			pushed_full_n = 1'b0;
		end
	end

	assign stat.pop = do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q          <= '0;
			wp_q          <= '0;
			fill_q        <= '0;
			cts_q         <= 1'b1;
			pushed_byte_q <= '0;
			pushed_full_q <= 1'b0;
			thr_q         <= THR_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (cmd.accept) begin
				fill_q        <= fill_n;
				cts_q         <= cts_n;
				pushed_full_q <= pushed_full_n;
				if (do_store) begin
					wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + PW'(1);
				end
				if (do_pop) begin
					rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + PW'(1);
				end
				if (is_push) begin
					pushed_byte_q <= din;
				end else if (do_slot) begin
					pushed_byte_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && do_store) begin
			mem[wp_q] <= din;
		end
		rd_q <= mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_byte_q <= do_slot ? pushed_byte_q : 8'h00;
			out_rv_q   <= do_slot || do_pop;
			out_drop_q <= is_rx && fifo_full;
			out_cts_q  <= cts_n;
			out_av_q   <= pushed_full_n || (fill_n != '0);
		end else if (cmd.load_rd) begin
			out_byte_q <= rd_q;
		end
	end

	assign m_tdata = {4'b0000, out_av_q, out_cts_q, out_drop_q, out_rv_q, out_byte_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FULL_CNT) |-> rp_q == wp_q)
		else $error("pointers disagree with fill count");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && do_store |=> fill_q == $past(fill_inc))
		else $error("store did not advance fill count");

endmodule

FILE: design/uart_rx_fifo_flow_control_core.sv
// Top level of the UART receive FIFO with clear-to-send flow control.
// Depends on urxf_pkg, urxf_ctrl and urxf_dpath.
//
// Input stream (s_*): one word per event. s_tuser carries the kind (receive, read,
// push back), s_tdata the received or pushed-back byte. Output stream (m_*): one word
// per accepted input word, in order. Config channel (cfg_*): flow threshold, always ready.
// The user writes it only while the block is idle; the block does not enforce this.
// Receive, push back, push-back slot read and empty read give their word in the cycle
// after accept. A FIFO pop first passes through the registered read of the byte store and
// the memory wait state, then its word is loaded into the output register.
// Throughput: one word per cycle for everything but pops, while the sink takes each word;
// a pop is followed by the memory wait state, in which no new word is taken. The next word
// is taken while the output word is being handed off.
// Reset: store empty, clear-to-send high, push-back slot empty, threshold 58. The
// store contents are not cleared. When the sink stalls, the output word holds and no
// new input word is accepted until it is taken.
module uart_rx_fifo_flow_control_core #(
	parameter int unsigned FIFO_DEPTH = urxf_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [urxf_pkg::IN_W-1:0]     s_tdata,  // [7:0] data_byte
	input  logic [urxf_pkg::KIND_W-1:0]   s_tuser,  // [1:0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] read_byte, [8] read_valid, [9] dropped, [10] clear_to_send,
	// [11] data_available, [15:12] zero
	output logic [urxf_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [urxf_pkg::THR_W-1:0]    cfg_data  // [6:0] flow_threshold
);
	import urxf_pkg::*;

	urxf_cmd_t  cmd;
	urxf_stat_t stat;

	assign cfg_ready = 1'b1;

	urxf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	urxf_dpath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: test/uart_rx_fifo_flow_control_core_tb.sv
// Self-checking testbench for uart_rx_fifo_flow_control_core: random and directed receive,
// read and push-back words, checked against a built-in FIFO and flow-control predictor.
// Depends on urxf_pkg and the design files only.
module uart_rx_fifo_flow_control_core_tb;
	import urxf_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEFAULT;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [3:0] pad;
		logic       avail;
		logic       cts;
		logic       dropped;
		logic       rvalid;
		logic [7:0] rbyte;
	} rx_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic [KIND_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [THR_W-1:0] cfg_data;

	// predictor state
	logic [7:0] byte_mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W:0] fill_level;
	logic cts_line;
	logic [7:0] slot_byte;
	logic slot_full;
	logic [THR_W-1:0] threshold;

	rx_word_t expected_rx_words [$];
	rx_word_t exp_word;
	rx_word_t got_word;
	int mismatch_count = 0;
	bit quiet_mode = 1'b0;
	bit hold_req = 1'b0;

	uart_rx_fifo_flow_control_core #(.FIFO_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic rx_word_t model_rx_event(logic [KIND_W-1:0] kind, logic [7:0] din);
		rx_word_t r = '0;
		case (kind)
			KIND_RECEIVE: begin
				if (fill_level < DEPTH) begin
					byte_mem[wr_ptr] = din;
					wr_ptr = wr_ptr + 1'b1;
					fill_level = fill_level + 1'b1;
					if (fill_level >= threshold)
						cts_line = 1'b0;
				end else begin
					r.dropped = 1'b1;
				end
			end
			KIND_READ: begin
				if (slot_full) begin
					r.rbyte = slot_byte;
					r.rvalid = 1'b1;
					slot_full = 1'b0;
					slot_byte = 8'h00;
				end else if (fill_level != 0) begin
					r.rbyte = byte_mem[rd_ptr];
					r.rvalid = 1'b1;
					rd_ptr = rd_ptr + 1'b1;
					fill_level = fill_level - 1'b1;
					if (fill_level < threshold)
						cts_line = 1'b1;
				end
			end
			KIND_PUSH: begin
				slot_byte = din;
				slot_full = 1'b1;
			end
			default: begin
			end
		endcase
		r.cts = cts_line;
		r.avail = slot_full || (fill_level != 0);
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_rx_words.push_back(model_rx_event(s_tuser, s_tdata));
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = m_tdata;
			if (expected_rx_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected output word %h", m_tdata);
			end else begin
				exp_word = expected_rx_words.pop_front();
				if (got_word.rbyte !== exp_word.rbyte || got_word.rvalid !== exp_word.rvalid ||
						got_word.dropped !== exp_word.dropped || got_word.cts !== exp_word.cts ||
						got_word.avail !== exp_word.avail || got_word.pad !== exp_word.pad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: exp byte %h valid %b drop %b cts %b avail %b pad %h, got byte %h valid %b drop %b cts %b avail %b pad %h",
							exp_word.rbyte, exp_word.rvalid, exp_word.dropped, exp_word.cts,
							exp_word.avail, exp_word.pad, got_word.rbyte, got_word.rvalid,
							got_word.dropped, got_word.cts, got_word.avail, got_word.pad);
				end
			end
		end
	end

	// sink: random stalls, optional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet_mode) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(logic [KIND_W-1:0] kind, logic [7:0] din);
		if (!quiet_mode) begin
			while ($urandom_range(99) < 13) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= din;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_rx_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		threshold = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(int count);
		int done = 0;
		int mode;
		int len;
		int p;
		logic [KIND_W-1:0] kind;
		while (done < count) begin
			mode = $urandom_range(2);
			len = $urandom_range(1, 90);
			for (int i = 0; i < len && done < count; i++) begin
				p = $urandom_range(99);
				case (mode)
					0: kind = (p < 82) ? KIND_RECEIVE : (p < 92) ? KIND_READ :
						(p < 98) ? KIND_PUSH : KIND_UNUSED;
					1: kind = (p < 82) ? KIND_READ : (p < 90) ? KIND_RECEIVE :
						(p < 98) ? KIND_PUSH : KIND_UNUSED;
					default: kind = (p < 40) ? KIND_RECEIVE : (p < 80) ? KIND_READ :
						(p < 95) ? KIND_PUSH : KIND_UNUSED;
				endcase
				send_word(kind, 8'($urandom_range(255)));
				if (kind != KIND_UNUSED) begin
					done++;
				end
			end
		end
	endtask

	task automatic test_directed();
		send_word(KIND_READ, 8'hff);
		send_word(KIND_UNUSED, 8'h3c);
		send_word(KIND_RECEIVE, 8'h00);
		send_word(KIND_RECEIVE, 8'hff);
		send_word(KIND_RECEIVE, 8'ha5);
		send_word(KIND_PUSH, 8'h00);
		send_word(KIND_UNUSED, 8'hff);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_PUSH, 8'h5a);
		send_word(KIND_PUSH, 8'hc3);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_PUSH, 8'hff);
		send_word(KIND_READ, 8'h00);
		send_word(KIND_READ, 8'h00);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_req = 1'b1;
		repeat (100) send_word(KIND_RECEIVE, 8'($urandom_range(255)));
		repeat (110) send_word(KIND_READ, 8'h00);
	endtask

	task automatic test_threshold_extremes();
		logic [THR_W-1:0] levels [4] = '{7'd0, 7'd1, 7'd64, 7'd127};
		foreach (levels[i]) begin
			write_threshold(levels[i]);
			run_traffic(100);
		end
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 4; ph++) begin
			write_threshold(7'($urandom_range(1, DEPTH)));
			quiet_mode = (ph == 2);
			run_traffic(180);
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_RECEIVE;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rd_ptr = '0;
		wr_ptr = '0;
		fill_level = '0;
		cts_line = 1'b1;
		slot_byte = 8'h00;
		slot_full = 1'b0;
		threshold = THR_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_threshold_extremes();
		test_random();
		wait_drained();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
